// File: sv/assert_macros.svh
// Assertion macros for the keyword spotter RTL.
// Checks are compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KW_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("keyword spotter check failed");
`define KW_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("keyword spotter forbidden condition");
`else
`define KW_ASSERT(label, clk, rst, prop)
`define KW_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// File: sv/kwspot_pkg.sv
// Shared types, constants and keyword table for the keyword spotter.
// No dependencies.
`default_nettype none

package kwspot_pkg;

   localparam int unsigned TOKEN_MAX_N = 8;
   localparam int unsigned KW_COUNT    = 32;
   localparam int unsigned TEXT_W      = 8 * TOKEN_MAX_N;

   localparam logic [3:0] TOKEN_MAX    = 4'd8;
   localparam logic [3:0] LEN_OVER     = 4'd9;
   localparam logic [7:0] NEWLINE_CODE = 8'h0A;

   // closed token, first character in the top byte, zero padded
   typedef struct packed {
      logic [TEXT_W-1:0] text;
      logic [3:0]        len;
   } tok_event_type;

   function automatic logic kw_is_break(input logic [7:0] c);
      logic brk;
      case (c) inside
         " ", "*", "-", "+", "/", ",", ";", "=",
         "<", ">", "(", ")", "[", "]", "{", "}": brk = 1'b1;
         NEWLINE_CODE:                           brk = 1'b1;
         default:                                brk = 1'b0;
      endcase
      return brk;
   endfunction

   function automatic logic [TEXT_W-1:0] kw_text(input logic [4:0] k);
      logic [TEXT_W-1:0] t;
      unique case (k)
         5'd0:  t = TEXT_W'("auto");
         5'd1:  t = TEXT_W'("break");
         5'd2:  t = TEXT_W'("case");
         5'd3:  t = TEXT_W'("char");
         5'd4:  t = TEXT_W'("const");
         5'd5:  t = TEXT_W'("continue");
         5'd6:  t = TEXT_W'("default");
         5'd7:  t = TEXT_W'("do");
         5'd8:  t = TEXT_W'("double");
         5'd9:  t = TEXT_W'("else");
         5'd10: t = TEXT_W'("enum");
         5'd11: t = TEXT_W'("extern");
         5'd12: t = TEXT_W'("float");
         5'd13: t = TEXT_W'("for");
         5'd14: t = TEXT_W'("goto");
         5'd15: t = TEXT_W'("if");
         5'd16: t = TEXT_W'("int");
         5'd17: t = TEXT_W'("long");
         5'd18: t = TEXT_W'("register");
         5'd19: t = TEXT_W'("return");
         5'd20: t = TEXT_W'("short");
         5'd21: t = TEXT_W'("signed");
         5'd22: t = TEXT_W'("sizeof");
         5'd23: t = TEXT_W'("static");
         5'd24: t = TEXT_W'("struct");
         5'd25: t = TEXT_W'("switch");
         5'd26: t = TEXT_W'("typedef");
         5'd27: t = TEXT_W'("union");
         5'd28: t = TEXT_W'("unsigned");
         5'd29: t = TEXT_W'("void");
         5'd30: t = TEXT_W'("volatile");
         default: t = TEXT_W'("while");
      endcase
      return t;
   endfunction

   function automatic logic [3:0] kw_len(input logic [4:0] k);
      logic [3:0] n;
      unique case (k)
         5'd7, 5'd15:                                     n = 4'd2;
         5'd13, 5'd16:                                    n = 4'd3;
         5'd0, 5'd2, 5'd3, 5'd9, 5'd10, 5'd14, 5'd17, 5'd29: n = 4'd4;
         5'd1, 5'd4, 5'd12, 5'd20, 5'd27, 5'd31:          n = 4'd5;
         5'd8, 5'd11, 5'd19, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25: n = 4'd6;
         5'd6, 5'd26:                                     n = 4'd7;
         default:                                         n = 4'd8;
      endcase
      return n;
   endfunction

   // keyword text moved up so that its first character is the top byte
   function automatic logic [TEXT_W-1:0] kw_aligned(input logic [4:0] k);
      logic [TEXT_W-1:0] t;
      t = kw_text(k) << (8 * (TOKEN_MAX_N - 32'(kw_len(k))));
      return t;
   endfunction

endpackage

`default_nettype wire

// File: sv/kwspot_tokenizer.sv
// Input register and token collector; emits one event per closed token of 1 to 8 bytes.
// Depends on kwspot_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module kwspot_tokenizer
   import kwspot_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire logic [7:0]    in_char,
   input  wire logic          in_eol,
   output logic               ev_valid,
   input  wire logic          ev_ready,
   output tok_event_type      ev
);

   logic          s1_valid_ff, s1_valid_in;
   logic [7:0]    char_ff;
   logic          eol_ff;
   logic [3:0]    len_ff, len_in;
   logic [7:0]    chars_ff [TOKEN_MAX_N];
   logic [7:0]    chars_in [TOKEN_MAX_N];
   logic          ev_valid_ff, ev_valid_in;
   tok_event_type ev_ff, ev_in;

   logic          brk, closes, emit, ev_free, s1_go;
   logic [3:0]    len_next;

   always_comb begin
      brk      = kw_is_break(char_ff);
      closes   = brk || eol_ff;
      len_next = len_ff;
      chars_in = chars_ff;
      if (!brk) begin
         if (len_ff < LEN_OVER) begin
            len_next = len_ff + 4'd1;
         end
         if (len_ff < TOKEN_MAX) begin
            chars_in[len_ff[2:0]] = char_ff;
         end
      end
      emit    = closes && (len_next != 4'd0) && (len_next <= TOKEN_MAX);
      ev_free = !ev_valid_ff || ev_ready;
      s1_go   = s1_valid_ff && (!emit || ev_free);
      in_ready = !s1_valid_ff || s1_go;

      s1_valid_in = s1_valid_ff;
      if (in_valid && in_ready) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end

      len_in = len_ff;
      if (s1_go) begin
         len_in = closes ? 4'd0 : len_next;
      end

      ev_valid_in = ev_valid_ff;
      if (s1_go && emit) begin
         ev_valid_in = 1'b1;
      end else if (ev_ready) begin
         ev_valid_in = 1'b0;
      end

      ev_in.len = len_next;
      for (int i = 0; i < TOKEN_MAX_N; i++) begin
         ev_in.text[TEXT_W-1-8*i -: 8] = (4'(i) < len_next) ? chars_in[i] : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         len_ff      <= 4'd0;
         ev_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         len_ff      <= len_in;
         ev_valid_ff <= ev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         char_ff <= in_char;
         eol_ff  <= in_eol;
      end
      if (s1_go) begin
         chars_ff <= chars_in;
      end
      if (s1_go && emit) begin
         ev_ff <= ev_in;
      end
   end

   assign ev_valid = ev_valid_ff;
   assign ev       = ev_ff;

   `KW_ASSERT(a_close_clears_len, clock, reset, (s1_go && closes) |=> (len_ff == 4'd0))
   `KW_ASSERT(a_event_len_range, clock, reset, ev_valid_ff |-> ((ev_ff.len != 4'd0) && (ev_ff.len <= TOKEN_MAX)))
   `KW_ASSERT_NEVER(a_len_over, clock, reset, len_ff > LEN_OVER)

endmodule

`default_nettype wire

// File: sv/kwspot_matcher.sv
// Parallel compare of a closed token with the 32 keywords, plus result register.
// Depends on kwspot_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module kwspot_matcher
   import kwspot_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          ev_valid,
   output logic               ev_ready,
   input  wire tok_event_type ev,
   output logic               out_valid,
   input  wire logic          out_ready,
   output logic [4:0]         out_id
);

   logic [KW_COUNT-1:0] hit_vec;
   logic                hit_any;
   logic [4:0]          hit_id;
   logic                out_valid_ff, out_valid_in;
   logic [4:0]          id_ff;
   logic                out_free, ev_go;

   always_comb begin
      hit_id = 5'd0;
      for (int k = 0; k < KW_COUNT; k++) begin
         hit_vec[k] = (ev.len == kw_len(5'(k))) && (ev.text == kw_aligned(5'(k)));
      end
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (hit_vec[k]) begin
            hit_id = 5'(k);
         end
      end
      hit_any  = |hit_vec;
      out_free = !out_valid_ff || out_ready;
      ev_ready = !hit_any || out_free;
      ev_go    = ev_valid && ev_ready;

      out_valid_in = out_valid_ff;
      if (ev_go && hit_any) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_go && hit_any) begin
         id_ff <= hit_id;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_id    = id_ff;

   `KW_ASSERT_NEVER(a_hit_unique, clock, reset, ev_valid && !$onehot0(hit_vec))
   `KW_ASSERT(a_out_from_event, clock, reset, $rose(out_valid_ff) |-> $past(ev_valid && hit_any))

endmodule

`default_nettype wire

// File: sv/c_keyword_token_spotter_core.sv
// C reserved-word spotter: top level joining tokenizer and matcher.
// Depends on kwspot_pkg, kwspot_tokenizer and kwspot_matcher.
//
// Usage:
//   req_* carries the source text, one byte per transfer in req_tdata;
//   req_tlast marks the last byte of a line and closes any open token.
//   Delimiters, blanks of type space and newline bytes split tokens.
//   rsp_* carries one transfer per closed token that equals a C keyword,
//   rsp_tdata[4:0] = keyword index (auto = 0 ... while = 31).
//   Tokens that match nothing, empty tokens and tokens over 8 bytes give
//   no transfer.
// Timing:
//   One byte accepted per cycle, sustained while req_tready stays high. A result
//   appears on rsp_tvalid once the byte that closes the token has passed the
//   input register, the token event register and the result register.
// Reset: synchronous, active high; drops any open token and pending result.
// Stall: while rsp_tready is low the result register holds. Bytes keep
//   flowing until a keyword waits in the event register and another token
//   closes in the input register; then req_tready falls.
`default_nettype none

module c_keyword_token_spotter_core
   import kwspot_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] char_code
   input  wire logic       req_tlast,   // line_end
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [4:0] keyword_id, [7:5] zero
);

   logic          ev_valid;
   logic          ev_ready;
   tok_event_type ev;
   logic [4:0]    keyword_id;

   kwspot_tokenizer u_tokenizer (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_char  (req_tdata),
      .in_eol   (req_tlast),
      .ev_valid (ev_valid),
      .ev_ready (ev_ready),
      .ev       (ev)
   );

   kwspot_matcher u_matcher (
      .clock     (clock),
      .reset     (reset),
      .ev_valid  (ev_valid),
      .ev_ready  (ev_ready),
      .ev        (ev),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_id    (keyword_id)
   );

   assign rsp_tdata = {3'b000, keyword_id};

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking bench for c_keyword_token_spotter_core: streams source bytes and
// predicts the C keyword index emitted for each closed token.
// Depends on the RTL files only (kwspot_pkg and the core with its submodules).
`default_nettype none

module tb;

   localparam int         TOKEN_CAP    = 8;
   localparam logic [3:0] LEN_SAT      = 4'd9;
   localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
   localparam int         QUIET_LIMIT  = 2000;
   localparam int         DRAIN_CYCLES = 10;
   localparam int         RANDOM_ITEMS = 1600;
   localparam string      DELIMS       = " *-+/,;=<>()[]{}";

   localparam string KW_WORD [32] = '{
      "auto", "break", "case", "char", "const", "continue", "default", "do",
      "double", "else", "enum", "extern", "float", "for", "goto", "if",
      "int", "long", "register", "return", "short", "signed", "sizeof", "static",
      "struct", "switch", "typedef", "union", "unsigned", "void", "volatile", "while"
   };

   typedef struct {
      logic [7:0] code;
      logic       eol;
      bit         hold;   // wait for all results before this transfer
   } src_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] char_code
   logic       req_tlast = 1'b0;    // line_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [4:0] keyword_id, [7:5] zero

   src_byte_type src_q[$];
   logic [4:0] kw_expected[$];
   logic [7:0] tok_chars[TOKEN_CAP];
   logic [3:0] tok_len = 4'd0;
   bit         hold_next = 1'b0;
   int         sent_n = 0;
   int         fail_n = 0;
   int         quiet_n = 0;

   c_keyword_token_spotter_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit is_delim(input logic [7:0] c);
      bit hit;
      hit = 1'b0;
      for (int i = 0; i < DELIMS.len(); i++) begin
         if (c == DELIMS[i]) hit = 1'b1;
      end
      return hit;
   endfunction

   // advance the token state by one byte; returns 1 when a keyword closes
   function automatic bit spot_keyword(input logic [7:0] c, input logic eol,
                                       output logic [4:0] id);
      bit brk;
      bit same;
      bit found;
      brk = is_delim(c) || (c == NEWLINE_BYTE);
      found = 1'b0;
      id = 5'd0;
      if (!brk) begin
         if (tok_len < TOKEN_CAP) tok_chars[tok_len[2:0]] = c;
         if (tok_len < LEN_SAT) tok_len = tok_len + 4'd1;
      end
      if (brk || eol) begin
         if (tok_len != 0 && tok_len <= TOKEN_CAP) begin
            for (int k = 0; k < 32; k++) begin
               same = (KW_WORD[k].len() == int'(tok_len));
               for (int i = 0; same && i < int'(tok_len); i++) begin
                  if (KW_WORD[k][i] != tok_chars[i]) same = 1'b0;
               end
               if (same && !found) begin
                  found = 1'b1;
                  id = 5'(k);
               end
            end
         end
         foreach (tok_chars[i]) tok_chars[i] = 8'h00;
         tok_len = 4'd0;
      end
      return found;
   endfunction

   task automatic add_byte(input logic [7:0] c, input logic eol);
      src_byte_type b;
      b.code = c;
      b.eol = eol;
      b.hold = hold_next;
      hold_next = 1'b0;
      src_q.push_back(b);
   endtask

   task automatic add_text(input string s, input bit mark_last);
      for (int i = 0; i < s.len(); i++) begin
         add_byte(s[i], mark_last && (i == s.len() - 1));
      end
   endtask

   function automatic logic [7:0] any_letter();
      return 8'($urandom_range(25)) + (($urandom_range(3) == 0) ? 8'h41 : 8'h61);
   endfunction

   task automatic add_random_token();
      string w;
      int pick;
      int pos;
      pick = $urandom_range(9);
      w = KW_WORD[$urandom_range(31)];
      if (pick == 6) begin
         pos = $urandom_range(w.len() - 1);
         if ($urandom_range(1) == 0) w.putc(pos, w[pos] ^ 8'h20);
         else w.putc(pos, any_letter());
      end else if (pick == 7) begin
         repeat ($urandom_range(1, 3)) w = $sformatf("%s%c", w, any_letter());
      end else if (pick == 8) begin
         w = "";
         repeat ($urandom_range(1, 10)) w = $sformatf("%s%c", w, any_letter());
      end else if (pick == 9) begin
         w = w.substr(0, $urandom_range(w.len() - 2));
      end
      case ($urandom_range(9))
         0, 1, 2, 3, 4: begin
            add_text(w, 1'b0);
            add_byte(DELIMS[$urandom_range(DELIMS.len() - 1)], 1'b0);
         end
         5: begin
            add_text(w, 1'b0);
            add_byte(NEWLINE_BYTE, $urandom_range(1));
         end
         6: add_text(w, 1'b1);
         7: begin
            add_text(w, 1'b0);
            add_byte(DELIMS[$urandom_range(DELIMS.len() - 1)], 1'b1);
         end
         8: begin
            add_text(w, 1'b0);
            add_byte(DELIMS[$urandom_range(DELIMS.len() - 1)], 1'b0);
            add_byte(DELIMS[$urandom_range(DELIMS.len() - 1)], 1'b0);
         end
         default: add_text(w, 1'b0);
      endcase
   endtask

   function automatic bit steady_phase();
      return sent_n >= 700 && sent_n < 1000;
   endfunction

   // sender
   always @(posedge clock) begin
      logic [4:0]   id;
      src_byte_type nxt;
      bit           go;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= 8'h00;
         req_tlast <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (spot_keyword(req_tdata, req_tlast, id)) kw_expected.push_back(id);
            sent_n++;
         end
         if (!(req_tvalid && !req_tready)) begin
            go = src_q.size() != 0 && (steady_phase() || $urandom_range(99) >= 8);
            if (go && src_q[0].hold && kw_expected.size() != 0) go = 1'b0;
            if (go) begin
               nxt = src_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= nxt.code;
               req_tlast <= nxt.eol;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      rsp_tready <= steady_phase() || ($urandom_range(99) >= 8);
   end

   // result checker
   always @(posedge clock) begin
      logic [4:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (kw_expected.size() == 0) begin
            $error("keyword_id: expected none, got %0d", rsp_tdata[4:0]);
            fail_n++;
         end else begin
            want = kw_expected.pop_front();
            if (rsp_tdata[4:0] !== want) begin
               $error("keyword_id: expected %0d, got %0d", want, rsp_tdata[4:0]);
               fail_n++;
            end
            if (rsp_tdata[7:5] !== 3'b000) begin
               $error("rsp_tdata pad: expected 0, got %0d", rsp_tdata[7:5]);
               fail_n++;
            end
         end
      end
   end

   // watchdog on transfers
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_n <= 0;
         end else if (quiet_n >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end else begin
            quiet_n <= quiet_n + 1;
         end
      end
   end

   initial begin
      foreach (tok_chars[i]) tok_chars[i] = 8'h00;

      // newline close, line end on a letter, line end on a delimiter
      add_text("do", 1'b0);
      add_byte(NEWLINE_BYTE, 1'b0);
      add_text("if", 1'b1);
      add_text("for", 1'b0);
      add_byte(";", 1'b1);
      // empty tokens
      add_text(", ", 1'b0);
      // wrong case and odd bytes that still belong to a token
      add_text("Do", 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(")", 1'b0);
      // too long, then a keyword of the maximum length
      add_text("unsignedx ", 1'b0);
      add_text("continue{", 1'b0);

      hold_next = 1'b1;
      while (src_q.size() < RANDOM_ITEMS) begin
         if ($urandom_range(99) < 10) begin
            add_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
         end else begin
            if ($urandom_range(149) == 0) hold_next = 1'b1;
            add_random_token();
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (src_q.size() != 0 || req_tvalid) @(posedge clock);
      while (kw_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_n == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
